### rtl/qmd_pkg.sv
// Shared types, constants and result packing for the Q16.16 multiply/divide unit.
`default_nettype none

package qmd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int MAG_W     = 2 * DATA_W - FRAC_BITS;   // width of product >> FRAC_BITS
   localparam int DIV_STEPS = DATA_W;                   // one quotient bit per step
   localparam int ITER_W    = $clog2(DIV_STEPS);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

   localparam logic       ACTION_MUL = 1'b0;
   localparam logic       ACTION_DIV = 1'b1;

   localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic                     action;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [1:0]               status_code;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture a new transaction
      logic setup;       // multiply, or classify and seed the divider
      logic div_step;    // one restoring division step
      logic pack_write;  // write packed result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_div;      // captured transaction is a divide
      logic div_early;   // divide finishes without iterating (zero or overflow)
   } stat_type;

   // Apply sign to a magnitude, saturating on overflow.
   function automatic rsp_type pack_result(input logic [MAG_W-1:0] mag, input logic neg);
      rsp_type r;
      if (neg) begin
         if (mag > MAG_W'(NEG_LIMIT)) begin
            r.result_value = NEG_LIMIT;
            r.status_code  = STATUS_OVERFLOW;
         end else begin
            r.result_value = ~mag[DATA_W-1:0] + DATA_W'(1);
            r.status_code  = STATUS_OK;
         end
      end else begin
         if (mag > MAG_W'(POS_LIMIT)) begin
            r.result_value = POS_LIMIT;
            r.status_code  = STATUS_OVERFLOW;
         end else begin
            r.result_value = mag[DATA_W-1:0];
            r.status_code  = STATUS_OK;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/q16_16_mul_div_unit.sv
// Top level of the signed Q16.16 multiply/divide unit.
//
// Usage:
//  - Input channel req_valid/req_ready/req_data carries one transaction:
//    action (0 multiply, 1 divide), operand_a and operand_b, signed Q16.16.
//  - Result channel rsp_valid/rsp_ready/rsp_data returns exactly one
//    transaction per input: result_value (Q16.16) and status_code
//    (0 ok, 1 overflow saturated, 2 divide by zero).
//  - Transactions are handled one at a time. req_ready is high only while
//    the sequencer is idle.
//  - From input acceptance to rsp_valid: multiply and early divide
//    outcomes (zero divisor, quotient overflow) pass through setup and pack;
//    a normal divide also runs the restoring divider, which produces one
//    quotient bit per cycle over 32 steps, between setup and pack.
//  - The result sits in an output register, so a new transaction is taken
//    while the previous result waits. A stalled receiver holds the next
//    result in the pack step until the output register frees.
//  - Reset (synchronous, active high) returns the sequencer to idle and
//    drops rsp_valid; any transaction in flight is discarded.
`default_nettype none

module q16_16_mul_div_unit import qmd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   cmd_type  cmd;    // sequencer commands to the datapath
   stat_type stat;   // operation class and early-divide flag back

   qmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   qmd_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/qmd_datapath.sv
// Datapath: operand magnitudes, multiplier, restoring divider and output register.
`default_nettype none

module qmd_datapath import qmd_pkg::*; (
   input  wire logic     clock,
   input  wire req_type  req_data,
   input  wire cmd_type  cmd,
   output      stat_type stat,
   output      rsp_type  rsp_data
);

   localparam logic [1:0] KIND_MUL  = 2'd0;
   localparam logic [1:0] KIND_DIV  = 2'd1;
   localparam logic [1:0] KIND_DIV0 = 2'd2;
   localparam logic [1:0] KIND_OVF  = 2'd3;

   logic              action_ff;
   logic [DATA_W-1:0] mag_a_ff, mag_b_ff;
   logic              neg_a_ff, neg_ff;
   logic [1:0]        kind_ff, kind_in;
   logic [2*DATA_W-1:0] prod_ff;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] num_ff, num_in;   // dividend bits in, quotient bits out
   rsp_type           out_ff, out_in;

   logic [DATA_W-1:0] in_mag_a, in_mag_b;
   logic              b_zero, div_ovf;
   logic [DATA_W:0]   trial, diff;

   always_comb begin
      in_mag_a = req_data.operand_a[DATA_W-1] ? ~req_data.operand_a + DATA_W'(1)
                                               : req_data.operand_a;
      in_mag_b = req_data.operand_b[DATA_W-1] ? ~req_data.operand_b + DATA_W'(1)
                                               : req_data.operand_b;
   end

   // quotient needs more than DATA_W bits when |a| >= |b| << FRAC_BITS
   assign b_zero  = (mag_b_ff == '0);
   assign div_ovf = ({{FRAC_BITS{1'b0}}, mag_a_ff} >= {mag_b_ff, {FRAC_BITS{1'b0}}});

   assign stat.is_div    = (action_ff == ACTION_DIV);
   assign stat.div_early = b_zero | div_ovf;

   // restoring step
   assign trial = {rem_ff, num_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, mag_b_ff};

   always_comb begin
      kind_in = kind_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      if (cmd.setup) begin
         if (action_ff == ACTION_MUL) kind_in = KIND_MUL;
         else if (b_zero)             kind_in = KIND_DIV0;
         else if (div_ovf)            kind_in = KIND_OVF;
         else                         kind_in = KIND_DIV;
         rem_in = mag_a_ff >> (DATA_W - FRAC_BITS);
         num_in = mag_a_ff << FRAC_BITS;
      end else if (cmd.div_step) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            num_in = {num_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            num_in = {num_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_MUL:  out_in = pack_result(prod_ff[2*DATA_W-1:FRAC_BITS], neg_ff);
         KIND_DIV:  out_in = pack_result(MAG_W'(num_ff), neg_ff);
         KIND_DIV0: begin
            out_in.result_value = neg_a_ff ? NEG_LIMIT : POS_LIMIT;
            out_in.status_code  = STATUS_DIV_ZERO;
         end
         default: begin
            out_in.result_value = neg_ff ? NEG_LIMIT : POS_LIMIT;
            out_in.status_code  = STATUS_OVERFLOW;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_data.action;
         mag_a_ff  <= in_mag_a;
         mag_b_ff  <= in_mag_b;
         neg_a_ff  <= req_data.operand_a[DATA_W-1];
         neg_ff    <= req_data.operand_a[DATA_W-1] ^ req_data.operand_b[DATA_W-1];
      end
      if (cmd.setup) prod_ff <= mag_a_ff * mag_b_ff;
      kind_ff <= kind_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      if (cmd.pack_write) out_ff <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

### rtl/qmd_ctrl.sv
// Controller: sequencing state machine, divide step counter and handshakes.
`default_nettype none

module qmd_ctrl import qmd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   output      logic     rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output      cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_PACK  = 2'd3;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_STEPS - 1);

   logic [1:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      iter_in        = iter_ff;
      cmd.load       = 1'b0;
      cmd.setup      = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.pack_write = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            iter_in   = '0;
            state_in  = (stat.is_div && !stat.div_early) ? ST_DIV : ST_PACK;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_LAST) state_in = ST_PACK;
         end
         ST_PACK: begin
            if (out_free) begin
               cmd.pack_write = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SETUP))
      else $error("accepted transaction did not enter setup");

   a_div_runs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && iter_ff != ITER_LAST) |=> (state_ff == ST_DIV))
      else $error("divide left early");

   a_div_ends_in_pack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && iter_ff == ITER_LAST) |=> (state_ff == ST_PACK))
      else $error("divide did not end in pack");

   a_pack_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PACK && rsp_valid_ff && !rsp_ready) |=>
      (state_ff == ST_PACK && rsp_valid_ff))
      else $error("result overwritten while output stalled");

endmodule

`default_nettype wire
